[design/imusbc_pkg.sv]
// Shared types and constants for the IMU scale and bias correction block.
`default_nettype none

package imusbc_pkg;

    localparam int DATA_W     = 32;
    localparam int RAW_W      = 16;
    localparam int CNT_W      = 14;
    localparam int SUM_W      = 46;
    localparam int MAG_W      = RAW_W + 1;
    localparam int PROD_W     = MAG_W + DATA_W;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEP_W = $clog2(SUM_W);

    localparam logic [1:0] OP_GYRO  = 2'd0;
    localparam logic [1:0] OP_ACCEL = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_REQ     = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_Y  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_Z  = 3'd7;

    localparam logic [DATA_W-1:0] GYRO_SCALE_RST  = 32'd286720;
    localparam logic [DATA_W-1:0] ACCEL_SCALE_RST = 32'd3998;
    localparam logic [CNT_W-1:0]  MIN_CAL_SAMPLES = 14'd5;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic [CNT_W-1:0]        cal_count;
        logic                    cal_kind;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic [1:0]               cal_status;
        logic                     accepted;
    } out_item_t;

endpackage

`default_nettype wire

[design/imusbc_div.sv]
// Serial signed divider, one quotient bit per cycle, truncating and saturating to 32 bits.
`default_nettype none

module imusbc_div (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic signed [imusbc_pkg::SUM_W-1:0]     dividend,
    input  wire logic [imusbc_pkg::CNT_W-1:0]            divisor,
    output logic                                         done,
    output logic signed [imusbc_pkg::DATA_W-1:0]         quotient
);

    localparam int SW = imusbc_pkg::SUM_W;
    localparam int CW = imusbc_pkg::CNT_W;
    localparam int DW = imusbc_pkg::DATA_W;
    localparam logic [imusbc_pkg::DIV_STEP_W-1:0] LAST_STEP =
        imusbc_pkg::DIV_STEP_W'(SW - 1);

    logic                                busy_reg;
    logic                                done_reg;
    logic [imusbc_pkg::DIV_STEP_W-1:0]   cnt_reg;
    logic [SW-1:0]                       quo_reg;
    logic [CW-1:0]                       rem_reg;
    logic [CW-1:0]                       dsr_reg;
    logic                                neg_reg;

    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;
    logic          fits;
    logic [CW-1:0] rem_next;
    logic          big;

    assign rem_sh   = {rem_reg, quo_reg[SW-1]};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = fits ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    assign big      = |quo_reg[SW-1:DW];

    always_comb
    begin
        if (neg_reg)
        begin
            if (big || (quo_reg[DW-1] && (|quo_reg[DW-2:0])))
                quotient = imusbc_pkg::S32_MIN;
            else
                quotient = -$signed(quo_reg[DW-1:0]);
        end
        else
        begin
            if (big || quo_reg[DW-1])
                quotient = imusbc_pkg::S32_MAX;
            else
                quotient = $signed(quo_reg[DW-1:0]);
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SW-1];
            quo_reg <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

[design/imu_scale_and_bias_correction_core.sv]
// Top level: IMU axis remap, Q16.16 scaling, bias removal and gyro bias calibration.
// Sample item: one 17x32 multiplier is used once per axis step (multiply, then truncate and
// saturate), then one subtract per axis, before the result goes to the output register.
// An item that completes a calibration also runs the serial divider once per axis.
// Start and unused commands skip to the output stage. Input resumes once the output register is loaded.
// Reset (asynchronous): default scales, zero biases, calibration idle, output empty.
`default_nettype none

module imu_scale_and_bias_correction_core #(
    parameter int MAX_CAL_SAMPLES = 10000
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire imusbc_pkg::in_item_t                  in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output imusbc_pkg::out_item_t                      out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [imusbc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [imusbc_pkg::DATA_W-1:0]         cfg_wdata
);

    localparam int DW = imusbc_pkg::DATA_W;
    localparam int CW = imusbc_pkg::CNT_W;
    localparam int SW = imusbc_pkg::SUM_W;
    localparam int MW = imusbc_pkg::MAG_W;
    localparam int PW = imusbc_pkg::PROD_W;
    localparam int FW = imusbc_pkg::FRAC_W;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CAL_SAMPLES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SCL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DIVW = 3'd4;
    localparam logic [2:0] ST_BIAS = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // configuration
    logic [DW-1:0]        gyro_scale_reg;
    logic [DW-1:0]        accel_scale_reg;
    logic signed [DW-1:0] gyro_bias_reg  [0:2];
    logic signed [DW-1:0] accel_bias_reg [0:2];

    // control and calibration state
    logic [2:0]           state_reg;
    logic [1:0]           ax_reg;
    logic [1:0]           phase_reg;
    logic [CW-1:0]        target_reg;
    logic [CW-1:0]        used_reg;
    logic signed [SW-1:0] sums_reg    [0:2];
    logic signed [DW-1:0] learned_reg [0:2];
    logic                 use_learned_reg;
    logic                 acc_reg;
    logic                 done_reg;
    logic                 out_valid_reg;

    // payload
    imusbc_pkg::in_item_t  item_reg;
    imusbc_pkg::out_item_t out_data_reg;
    logic [PW-1:0]         prod_reg;
    logic                  neg_reg;
    logic signed [DW-1:0]  t_reg   [0:2];
    logic signed [DW-1:0]  res_reg [0:2];
    logic                  accepted_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 start_ok;
    logic                 gyro_acc;
    logic [CW-1:0]        used_inc;
    logic                 cal_done;
    logic signed [MW-1:0] v17;
    logic [MW-1:0]        mag17;
    logic [DW-1:0]        scale_sel;
    logic [PW-1:0]        prod_next;
    logic [DW:0]          p33;
    logic [DW-1:0]        mag_c;
    logic signed [DW-1:0] t_val;
    logic signed [DW-1:0] t_sel;
    logic signed [DW-1:0] bias_sel;
    logic signed [SW-1:0] sum_sel;
    logic signed [DW:0]   diff;
    logic signed [DW-1:0] diff_sat;
    logic                 div_start;
    logic                 div_done;
    logic signed [DW-1:0] div_q;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign start_ok = (in_data.cal_kind == 1'b0)
                   && (in_data.cal_count >= imusbc_pkg::MIN_CAL_SAMPLES)
                   && (in_data.cal_count <= MAX_CNT)
                   && (phase_reg != imusbc_pkg::PH_REQ)
                   && (phase_reg != imusbc_pkg::PH_COLLECT);

    assign gyro_acc = (phase_reg == imusbc_pkg::PH_REQ) || (phase_reg == imusbc_pkg::PH_COLLECT);
    assign used_inc = used_reg + 1'b1;
    assign cal_done = gyro_acc && (used_inc >= target_reg) && (used_inc != '0);

    // axis remap: x from raw y, y from raw x, z from negated raw z
    always_comb
    begin
        case (ax_reg)
            AX_X:    v17 = MW'(item_reg.raw_y);
            AX_Y:    v17 = MW'(item_reg.raw_x);
            default: v17 = -MW'(item_reg.raw_z);
        endcase
    end

    assign mag17     = v17[MW-1] ? MW'(-v17) : MW'(v17);
    assign scale_sel = (item_reg.operation == imusbc_pkg::OP_ACCEL) ? accel_scale_reg
                                                                    : gyro_scale_reg;
    assign prod_next = {{DW{1'b0}}, mag17} * {{MW{1'b0}}, scale_sel};

    // truncate the Q16.16 product, clamp magnitude, apply sign
    assign p33   = prod_reg[PW-1:FW];
    assign mag_c = (p33 > {1'b0, 1'b1, {(DW-1){1'b0}}}) ? {1'b1, {(DW-1){1'b0}}} : p33[DW-1:0];

    always_comb
    begin
        if (neg_reg)
            t_val = -$signed(mag_c);
        else if (mag_c[DW-1])
            t_val = imusbc_pkg::S32_MAX;
        else
            t_val = $signed(mag_c);
    end

    always_comb
    begin
        case (ax_reg)
            AX_X:
            begin
                t_sel   = t_reg[0];
                sum_sel = sums_reg[0];
            end
            AX_Y:
            begin
                t_sel   = t_reg[1];
                sum_sel = sums_reg[1];
            end
            default:
            begin
                t_sel   = t_reg[2];
                sum_sel = sums_reg[2];
            end
        endcase
    end

    always_comb
    begin
        case (ax_reg)
            AX_X:
                bias_sel = (item_reg.operation == imusbc_pkg::OP_ACCEL) ? accel_bias_reg[0]
                         : (use_learned_reg ? learned_reg[0] : gyro_bias_reg[0]);
            AX_Y:
                bias_sel = (item_reg.operation == imusbc_pkg::OP_ACCEL) ? accel_bias_reg[1]
                         : (use_learned_reg ? learned_reg[1] : gyro_bias_reg[1]);
            default:
                bias_sel = (item_reg.operation == imusbc_pkg::OP_ACCEL) ? accel_bias_reg[2]
                         : (use_learned_reg ? learned_reg[2] : gyro_bias_reg[2]);
        endcase
    end

    assign diff = (DW+1)'(t_sel) - (DW+1)'(bias_sel);

    always_comb
    begin
        if (diff[DW] != diff[DW-1])
            diff_sat = diff[DW] ? imusbc_pkg::S32_MIN : imusbc_pkg::S32_MAX;
        else
            diff_sat = diff[DW-1:0];
    end

    assign div_start = state_reg == ST_DIV;

    imusbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sel),
        .divisor  (used_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_scale_reg  <= imusbc_pkg::GYRO_SCALE_RST;
            accel_scale_reg <= imusbc_pkg::ACCEL_SCALE_RST;
            for (int i = 0; i < 3; i++)
            begin
                gyro_bias_reg[i]  <= '0;
                accel_bias_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                imusbc_pkg::REG_GYRO_SCALE:  gyro_scale_reg    <= cfg_wdata;
                imusbc_pkg::REG_ACCEL_SCALE: accel_scale_reg   <= cfg_wdata;
                imusbc_pkg::REG_GYRO_BIAS_X: gyro_bias_reg[0]  <= $signed(cfg_wdata);
                imusbc_pkg::REG_GYRO_BIAS_Y: gyro_bias_reg[1]  <= $signed(cfg_wdata);
                imusbc_pkg::REG_GYRO_BIAS_Z: gyro_bias_reg[2]  <= $signed(cfg_wdata);
                imusbc_pkg::REG_ACC_BIAS_X:  accel_bias_reg[0] <= $signed(cfg_wdata);
                imusbc_pkg::REG_ACC_BIAS_Y:  accel_bias_reg[1] <= $signed(cfg_wdata);
                imusbc_pkg::REG_ACC_BIAS_Z:  accel_bias_reg[2] <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ax_reg          <= AX_X;
            phase_reg       <= imusbc_pkg::PH_IDLE;
            target_reg      <= '0;
            used_reg        <= '0;
            use_learned_reg <= 1'b0;
            acc_reg         <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sums_reg[i]    <= '0;
                learned_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        ax_reg <= AX_X;
                        case (in_data.operation)
                            imusbc_pkg::OP_GYRO:
                            begin
                                acc_reg  <= gyro_acc;
                                done_reg <= cal_done;
                                if (gyro_acc)
                                begin
                                    used_reg  <= used_inc;
                                    phase_reg <= cal_done ? imusbc_pkg::PH_DONE
                                                          : imusbc_pkg::PH_COLLECT;
                                end
                                state_reg <= ST_MUL;
                            end
                            imusbc_pkg::OP_ACCEL:
                            begin
                                acc_reg   <= 1'b0;
                                done_reg  <= 1'b0;
                                state_reg <= ST_MUL;
                            end
                            imusbc_pkg::OP_START:
                            begin
                                if (start_ok)
                                begin
                                    phase_reg  <= imusbc_pkg::PH_REQ;
                                    target_reg <= in_data.cal_count;
                                    used_reg   <= '0;
                                    for (int i = 0; i < 3; i++)
                                        sums_reg[i] <= '0;
                                end
                                state_reg <= ST_OUT;
                            end
                            default:
                                state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_MUL:
                    state_reg <= ST_SCL;
                ST_SCL:
                begin
                    if (acc_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (ax_reg == 2'(i))
                                sums_reg[i] <= sum_sel + SW'(t_val);
                        end
                    end
                    if (ax_reg == AX_Z)
                    begin
                        ax_reg    <= AX_X;
                        state_reg <= done_reg ? ST_DIV : ST_BIAS;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                    state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (ax_reg == 2'(i))
                                learned_reg[i] <= div_q;
                        end
                        if (ax_reg == AX_Z)
                        begin
                            use_learned_reg <= 1'b1;
                            ax_reg          <= AX_X;
                            state_reg       <= ST_BIAS;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_BIAS:
                begin
                    if (ax_reg == AX_Z)
                    begin
                        ax_reg    <= AX_X;
                        state_reg <= ST_OUT;
                    end
                    else
                        ax_reg <= ax_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            item_reg     <= in_data;
            accepted_reg <= (in_data.operation != imusbc_pkg::OP_START) || start_ok;
            for (int i = 0; i < 3; i++)
                res_reg[i] <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            neg_reg  <= v17[MW-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (state_reg == ST_SCL && ax_reg == 2'(i))
                t_reg[i] <= t_val;
            if (state_reg == ST_BIAS && ax_reg == 2'(i))
                res_reg[i] <= diff_sat;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.out_x      <= res_reg[0];
            out_data_reg.out_y      <= res_reg[1];
            out_data_reg.out_z      <= res_reg[2];
            out_data_reg.cal_status <= phase_reg;
            out_data_reg.accepted   <= accepted_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVW)
        else $error("divider finished outside the wait state");

    a_collect_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == imusbc_pkg::PH_COLLECT |-> used_reg < target_reg)
        else $error("collecting with the sample target already reached");

    a_learned_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(use_learned_reg) |-> $past(state_reg) == ST_DIVW)
        else $error("learned bias enabled without a finished division");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.accepted) |->
            (out_data_reg.out_x == '0 && out_data_reg.out_y == '0 && out_data_reg.out_z == '0))
        else $error("refused start item carries nonzero axes");
`endif

endmodule

`default_nettype wire
